// ===== rtl/mic_pkg.sv =====
// ----------------------------------------------------------------------------
// mic_pkg
// shared constants and the job record passed from front to back
// ----------------------------------------------------------------------------
package mic_pkg;

  localparam int NLANE  = 9;
  localparam int AW     = 16;
  localparam int ADJW   = 33;
  localparam int AMW    = 32;
  localparam int DW     = 49;
  localparam int MW     = 48;
  localparam int FRAC   = 28;
  localparam int NUMW   = 61;
  localparam int QW     = 32;
  localparam int DSTAGE = 32;
  localparam int FDEPTH = 2;

  localparam logic [QW-1:0] INV_MAX_POS = 32'h7fff_ffff;
  localparam logic [QW-1:0] INV_MAX_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [NLANE-1:0][AMW-1:0] adj_mag;
    logic [NLANE-1:0]          adj_neg;
    logic [DW-1:0]             det;
    logic [MW-1:0]             det_mag;
    logic                      singular;
  } mic_job_t;

endpackage

// ===== rtl/mic_front.sv =====
// ----------------------------------------------------------------------------
// mic_front
// cofactors, determinant, signs and magnitudes, singular check
// ----------------------------------------------------------------------------
module mic_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic [mic_pkg::NLANE-1:0][mic_pkg::AW-1:0] m,
  output logic                                   job_valid,
  output mic_pkg::mic_job_t                      job
);

  localparam int LA [9] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
  localparam int LB [9] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
  localparam int RA [9] = '{5, 7, 4, 5, 6, 3, 6, 6, 1};
  localparam int RB [9] = '{7, 2, 2, 6, 2, 2, 4, 1, 3};

  logic                              a_valid, b_valid, c_valid, d_valid;
  logic signed [mic_pkg::AW-1:0]     a_m [9];
  logic signed [31:0]                b_pl [9];
  logic signed [31:0]                b_pr [9];
  logic signed [mic_pkg::AW-1:0]     b_a [3];
  logic signed [mic_pkg::ADJW-1:0]   c_adj [9];
  logic signed [mic_pkg::AW-1:0]     c_a [3];
  logic signed [mic_pkg::ADJW-1:0]   d_adj [9];
  logic signed [mic_pkg::DW-1:0]     d_dp [3];
  logic signed [mic_pkg::ADJW-1:0]   diff [9];
  logic signed [mic_pkg::DW-1:0]     det_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      d_valid   <= c_valid;
      job_valid <= d_valid;
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      diff[k] = mic_pkg::ADJW'(b_pl[k]) - mic_pkg::ADJW'(b_pr[k]);
    end
    det_sum = d_dp[0] + d_dp[1] + d_dp[2];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      a_m[k]  <= signed'(m[k]);
      b_pl[k] <= a_m[LA[k]] * a_m[LB[k]];
      b_pr[k] <= a_m[RA[k]] * a_m[RB[k]];
      c_adj[k] <= (k % 2 == 1) ? -diff[k] : diff[k];
      d_adj[k] <= c_adj[k];
      job.adj_neg[k] <= d_adj[k][mic_pkg::ADJW-1];
      job.adj_mag[k] <= d_adj[k][mic_pkg::ADJW-1] ? mic_pkg::AMW'(-d_adj[k])
                                                  : mic_pkg::AMW'(d_adj[k]);
    end
    for (int j = 0; j < 3; j++) begin
      b_a[j]  <= a_m[j];
      c_a[j]  <= b_a[j];
      d_dp[j] <= c_a[j] * c_adj[3*j];
    end
    job.det      <= det_sum;
    job.det_mag  <= det_sum[mic_pkg::DW-1] ? mic_pkg::MW'(-det_sum) : mic_pkg::MW'(det_sum);
    job.singular <= (det_sum == '0);
  end

endmodule

// ===== rtl/mic_fifo.sv =====
// ----------------------------------------------------------------------------
// mic_fifo
// short job queue between front and back, show-ahead read
// ----------------------------------------------------------------------------
module mic_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mic_pkg::mic_job_t push_job,
  input  logic              pop,
  output mic_pkg::mic_job_t pop_job,
  output logic              empty,
  output logic              full
);

  mic_pkg::mic_job_t mem [mic_pkg::FDEPTH];
  logic [$clog2(mic_pkg::FDEPTH)-1:0] wptr, rptr;
  logic [$clog2(mic_pkg::FDEPTH):0]   count;
  logic                               do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == ($clog2(mic_pkg::FDEPTH)+1)'(mic_pkg::FDEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      count <= count + (do_push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= push_job;
  end

endmodule

// ===== rtl/mic_div_lane.sv =====
// ----------------------------------------------------------------------------
// mic_div_lane
// pipelined rounded divide of one adjugate entry, one quotient bit per stage
// ----------------------------------------------------------------------------
module mic_div_lane (
  input  logic                    clk,
  input  logic [mic_pkg::AMW-1:0] adj_mag,
  input  logic                    adj_neg,
  input  logic [mic_pkg::MW-1:0]  det_mag,
  input  logic                    det_neg,
  output logic [mic_pkg::QW-1:0]  inv
);

  localparam int NS = mic_pkg::DSTAGE;
  localparam int MW = mic_pkg::MW;
  localparam int QW = mic_pkg::QW;

  logic [mic_pkg::NUMW-1:0] numr;
  logic                     ovf_in;
  logic [MW-1:0]            rem  [NS+1];
  logic [QW-1:0]            low  [NS+1];
  logic [QW-1:0]            q    [NS+1];
  logic [MW-1:0]            den  [NS+1];
  logic                     ovf  [NS+1];
  logic                     neg  [NS+1];
  logic [MW:0]              tt   [NS+1];
  logic [MW:0]              dd   [NS+1];
  logic                     ge   [NS+1];
  logic [QW-1:0]            qf;

  always_comb begin
    numr   = {adj_mag, mic_pkg::FRAC'(0)} + mic_pkg::NUMW'(det_mag >> 1);
    ovf_in = {(MW+QW-mic_pkg::NUMW)'(0), numr} >= {det_mag, QW'(0)};
    tt[0] = '0;
    dd[0] = '0;
    ge[0] = 1'b0;
    for (int s = 1; s <= NS; s++) begin
      tt[s] = {rem[s-1], low[s-1][QW-1]};
      ge[s] = tt[s] >= {1'b0, den[s-1]};
      dd[s] = tt[s] - {1'b0, den[s-1]};
    end
    qf = q[NS];
  end

  always_ff @(posedge clk) begin
    rem[0] <= MW'(numr[mic_pkg::NUMW-1:QW]);
    low[0] <= numr[QW-1:0];
    q[0]   <= '0;
    den[0] <= det_mag;
    ovf[0] <= ovf_in;
    neg[0] <= adj_neg ^ det_neg;
    for (int s = 1; s <= NS; s++) begin
      rem[s] <= ge[s] ? dd[s][MW-1:0] : tt[s][MW-1:0];
      low[s] <= low[s-1] << 1;
      q[s]   <= {q[s-1][QW-2:0], ge[s]};
      den[s] <= den[s-1];
      ovf[s] <= ovf[s-1];
      neg[s] <= neg[s-1];
    end
    if (neg[NS]) begin
      inv <= (ovf[NS] || qf > mic_pkg::INV_MAX_NEG) ? mic_pkg::INV_MAX_NEG : -qf;
    end else begin
      inv <= (ovf[NS] || qf[QW-1]) ? mic_pkg::INV_MAX_POS : qf;
    end
  end

endmodule

// ===== rtl/mic_back.sv =====
// ----------------------------------------------------------------------------
// mic_back
// nine divider lanes, singular override, result register
// ----------------------------------------------------------------------------
module mic_back (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       job_valid,
  input  mic_pkg::mic_job_t                          job,
  output logic                                       res_valid,
  output logic [mic_pkg::NLANE-1:0][mic_pkg::QW-1:0] inv,
  output logic [mic_pkg::DW-1:0]                     det,
  output logic                                       singular
);

  localparam int LAT = mic_pkg::DSTAGE + 2;

  logic [mic_pkg::NLANE-1:0][mic_pkg::QW-1:0] lane_q;
  logic                    sb_valid [LAT];
  logic                    sb_sing  [LAT];
  logic [mic_pkg::DW-1:0]  sb_det   [LAT];

  for (genvar k = 0; k < mic_pkg::NLANE; k++) begin : g_lane
    mic_div_lane u_lane (
      .clk     (clk),
      .adj_mag (job.adj_mag[k]),
      .adj_neg (job.adj_neg[k]),
      .det_mag (job.det_mag),
      .det_neg (job.det[mic_pkg::DW-1]),
      .inv     (lane_q[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < LAT; s++) sb_valid[s] <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      sb_valid[0] <= job_valid;
      for (int s = 1; s < LAT; s++) sb_valid[s] <= sb_valid[s-1];
      res_valid <= sb_valid[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    sb_sing[0] <= job.singular;
    sb_det[0]  <= job.det;
    for (int s = 1; s < LAT; s++) begin
      sb_sing[s] <= sb_sing[s-1];
      sb_det[s]  <= sb_det[s-1];
    end
    for (int k = 0; k < mic_pkg::NLANE; k++) begin
      inv[k] <= sb_sing[LAT-1] ? '0 : lane_q[k];
    end
    det      <= sb_det[LAT-1];
    singular <= sb_sing[LAT-1];
  end

endmodule

// ===== rtl/mat3_inverse_by_cofactors.sv =====
// ----------------------------------------------------------------------------
// mat3_inverse_by_cofactors
// 3x3 matrix inverse by adjugate and determinant, fixed point
//
// a matrix item is taken at a clock edge with start high and busy low; the
// nine q4.12 entries sit on m00..m22 at that edge.
// each result appears on inv00..inv22, determinant and singular for exactly
// one cycle with done high; the receiver cannot stall.
// from the accepting edge to the done cycle an item passes five front
// stages for cofactors and determinant, the job queue, then 32 quotient
// stages (one bit each) plus setup and saturation in nine divider lanes.
// throughput is one item per cycle; busy stays low in normal use, it only
// reflects a full job queue.
// a singular matrix gives zero inverse entries and singular high.
// reset empties the pipeline and the queue; items in flight are dropped.
// ----------------------------------------------------------------------------
module mat3_inverse_by_cofactors (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] m00,
  input  logic [15:0] m01,
  input  logic [15:0] m02,
  input  logic [15:0] m10,
  input  logic [15:0] m11,
  input  logic [15:0] m12,
  input  logic [15:0] m20,
  input  logic [15:0] m21,
  input  logic [15:0] m22,
  output logic        done,
  output logic [31:0] inv00,
  output logic [31:0] inv01,
  output logic [31:0] inv02,
  output logic [31:0] inv10,
  output logic [31:0] inv11,
  output logic [31:0] inv12,
  output logic [31:0] inv20,
  output logic [31:0] inv21,
  output logic [31:0] inv22,
  output logic [48:0] determinant,
  output logic        singular
);

  logic [mic_pkg::NLANE-1:0][mic_pkg::AW-1:0] m;
  logic [mic_pkg::NLANE-1:0][mic_pkg::QW-1:0] inv;
  logic              f_valid, q_empty, q_full;
  mic_pkg::mic_job_t f_job, b_job;

  assign m    = {m22, m21, m20, m12, m11, m10, m02, m01, m00};
  assign busy = q_full;

  mic_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .m         (m),
    .job_valid (f_valid),
    .job       (f_job)
  );

  mic_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (f_valid),
    .push_job (f_job),
    .pop      (!q_empty),
    .pop_job  (b_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  mic_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!q_empty),
    .job       (b_job),
    .res_valid (done),
    .inv       (inv),
    .det       (determinant),
    .singular  (singular)
  );

  assign inv00 = inv[0];
  assign inv01 = inv[1];
  assign inv02 = inv[2];
  assign inv10 = inv[3];
  assign inv11 = inv[4];
  assign inv12 = inv[5];
  assign inv20 = inv[6];
  assign inv21 = inv[7];
  assign inv22 = inv[8];

endmodule
